// File: sv/sil_pkg.sv
package sil_pkg;

    localparam int DEF_NUM_TABLES        = 32;
    localparam int DEF_ENTRIES_PER_TABLE = 512;

    localparam int POS_W   = 32;
    localparam int CHROM_W = 5;
    localparam int EIDX_W  = 9;
    localparam int FUNC_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_VERIFY = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   range_start;
        logic [POS_W-1:0]   range_end;
        logic [EIDX_W-1:0]  entry_index;
    } sil_in_t;

    typedef struct packed {
        logic              hit;
        logic [EIDX_W-1:0] hit_index;
        logic              table_full;
    } sil_out_t;

endpackage

// File: sv/sorted_interval_lookup_core.sv
// Per-table sorted interval lookup. Each of NUM_TABLES tables holds up to
// ENTRIES_PER_TABLE half-open intervals [start, end), appended in load order
// and kept in one on-chip interval memory; per-table fill counts sit in a small
// count memory whose valid bits are cleared at reset. One item is worked at a
// time. A load, an unused code, an out-of-range table or a verify past the count
// goes from the count read straight to the result step; a verify of a stored
// entry first reads that entry. A search runs its probes one after another: each
// probe is one read of the single interval memory port, a pass needs at most
// ceil(log2(count + 1)) probes, and a miss on the start with end > start runs a
// second pass. s_ready is raised again once the result is registered. The
// result sits in an output register; a stalled result holds the block in its final
// step until the transfer on the result channel.
module sorted_interval_lookup_core #(
    parameter int NUM_TABLES        = sil_pkg::DEF_NUM_TABLES,
    parameter int ENTRIES_PER_TABLE = sil_pkg::DEF_ENTRIES_PER_TABLE
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sil_pkg::sil_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sil_pkg::sil_out_t m_data
);
    import sil_pkg::*;

    localparam int TBL_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int IDX_W  = $clog2(ENTRIES_PER_TABLE);
    localparam int CNT_W  = $clog2(ENTRIES_PER_TABLE + 1);
    localparam int LO_W   = (CNT_W > EIDX_W) ? CNT_W : EIDX_W;
    localparam int DEPTH  = NUM_TABLES * ENTRIES_PER_TABLE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CNT    = 3'd1;
    localparam logic [2:0] ST_PROBE  = 3'd2;
    localparam logic [2:0] ST_VERIFY = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;

    logic [2:0]           state_reg, state_next;
    sil_in_t              item_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [LO_W-1:0]      lo_reg, lo_next;
    logic [LO_W-1:0]      hp_reg, hp_next;
    logic [IDX_W-1:0]     mid_reg, mid_next;
    logic                 pass_reg, pass_next;
    sil_out_t             res_reg, res_next;
    logic                 m_valid_reg;
    sil_out_t             m_data_reg;

    logic [2*POS_W-1:0]   ivl_mem [DEPTH];
    logic [2*POS_W-1:0]   ivl_rd_reg;
    logic                 ivl_we, ivl_re;
    logic [ADDR_W-1:0]    ivl_waddr, ivl_raddr;

    logic [CNT_W-1:0]     cnt_mem [NUM_TABLES];
    logic [NUM_TABLES-1:0] cnt_vld_reg;
    logic [CNT_W-1:0]     cnt_rd_reg;
    logic                 cnt_rd_vld_reg;
    logic                 cnt_we;

    logic                 s_fire, out_free;
    logic                 s_tbl_ok, tbl_ok;
    logic [TBL_W-1:0]     s_tbl, tbl;
    logic [CNT_W-1:0]     cnt_cur;
    logic [LO_W-1:0]      idx_ext, cnt_ext, mid_ext;
    logic [POS_W-1:0]     s_word, e_word, pos;
    logic                 in_hit, go_right, retry;
    logic [LO_W-1:0]      nlo, nhp, slo, shp;
    logic [LO_W:0]        msum;
    logic [IDX_W-1:0]     smid;
    logic                 scont;

    function automatic logic [ADDR_W-1:0] ivl_addr(input logic [TBL_W-1:0] t,
                                                   input logic [IDX_W-1:0] i);
        ivl_addr = ADDR_W'(ADDR_W'(t) * ADDR_W'(ENTRIES_PER_TABLE)) + ADDR_W'(i);
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign s_tbl_ok = (32'(s_data.chrom) < 32'(NUM_TABLES));
    assign s_tbl    = TBL_W'(s_data.chrom);
    assign tbl_ok   = (32'(item_reg.chrom) < 32'(NUM_TABLES));
    assign tbl      = TBL_W'(item_reg.chrom);

    assign cnt_cur  = cnt_rd_vld_reg ? cnt_rd_reg : '0;
    assign idx_ext  = LO_W'(item_reg.entry_index);
    assign cnt_ext  = LO_W'(cnt_cur);
    assign mid_ext  = LO_W'(mid_reg);

    assign s_word   = ivl_rd_reg[2*POS_W-1:POS_W];
    assign e_word   = ivl_rd_reg[POS_W-1:0];
    assign pos      = pass_reg ? item_reg.range_end : item_reg.range_start;
    assign in_hit   = (s_word <= pos) && (pos < e_word);
    assign go_right = (s_word < pos);
    assign nlo      = go_right ? LO_W'(mid_ext + LO_W'(1)) : lo_reg;
    assign nhp      = go_right ? hp_reg : mid_ext;
    assign retry    = !(nlo < nhp) && !pass_reg
                      && (item_reg.range_end > item_reg.range_start);

    always_comb begin
        if (state_reg == ST_CNT) begin
            slo = idx_ext;
            shp = cnt_ext;
        end else if (retry) begin
            slo = idx_ext;
            shp = LO_W'(cnt_reg);
        end else begin
            slo = nlo;
            shp = nhp;
        end
    end

    assign scont = (slo < shp);
    assign msum  = {1'b0, slo} + {1'b0, shp} - (LO_W + 1)'(1);
    assign smid  = IDX_W'(msum[LO_W:1]);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lo_next    = lo_reg;
        hp_next    = hp_reg;
        mid_next   = mid_reg;
        pass_next  = pass_reg;
        res_next   = res_reg;
        ivl_we     = 1'b0;
        ivl_re     = 1'b0;
        ivl_waddr  = ivl_addr(tbl, IDX_W'(cnt_cur));
        ivl_raddr  = ivl_addr(tbl, smid);
        cnt_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_CNT;
                end
            end
            ST_CNT: begin
                res_next   = '0;
                cnt_next   = cnt_cur;
                pass_next  = 1'b0;
                lo_next    = slo;
                hp_next    = shp;
                mid_next   = smid;
                state_next = ST_RESP;
                if (tbl_ok) begin
                    unique case (item_reg.func)
                        FUNC_LOAD: begin
                            if (cnt_cur >= CNT_W'(ENTRIES_PER_TABLE)) begin
                                res_next.table_full = 1'b1;
                            end else begin
                                ivl_we = 1'b1;
                                cnt_we = 1'b1;
                            end
                        end
                        FUNC_SEARCH: begin
                            if (scont) begin
                                ivl_re     = 1'b1;
                                state_next = ST_PROBE;
                            end
                        end
                        FUNC_VERIFY: begin
                            if (idx_ext < cnt_ext) begin
                                ivl_re     = 1'b1;
                                ivl_raddr  = ivl_addr(tbl, IDX_W'(item_reg.entry_index));
                                state_next = ST_VERIFY;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (in_hit) begin
                    res_next.hit       = 1'b1;
                    res_next.hit_index = EIDX_W'(mid_ext);
                    state_next         = ST_RESP;
                end else begin
                    lo_next  = slo;
                    hp_next  = shp;
                    mid_next = smid;
                    if (retry) begin
                        pass_next = 1'b1;
                    end
                    if (scont) begin
                        ivl_re = 1'b1;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_VERIFY: begin
                if ((s_word <= item_reg.range_start) && (e_word >= item_reg.range_end)) begin
                    res_next.hit       = 1'b1;
                    res_next.hit_index = item_reg.entry_index;
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_vld_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cnt_we) begin
                cnt_vld_reg[tbl] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_data;
        end
        cnt_reg  <= cnt_next;
        lo_reg   <= lo_next;
        hp_reg   <= hp_next;
        mid_reg  <= mid_next;
        pass_reg <= pass_next;
        res_reg  <= res_next;
        if (state_reg == ST_RESP && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_tbl_ok) begin
            cnt_rd_reg     <= cnt_mem[s_tbl];
            cnt_rd_vld_reg <= cnt_vld_reg[s_tbl];
        end else if (s_fire) begin
            cnt_rd_vld_reg <= 1'b0;
        end
        if (cnt_we) begin
            cnt_mem[tbl] <= CNT_W'(cnt_cur + CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (ivl_we) begin
            ivl_mem[ivl_waddr] <= {item_reg.range_start, item_reg.range_end};
        end
        if (ivl_re) begin
            ivl_rd_reg <= ivl_mem[ivl_raddr];
        end
    end

endmodule

// File: tb/interval_lookup_checker.sv
`timescale 1ns / 1ps

module interval_lookup_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  sil_pkg::sil_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  sil_pkg::sil_out_t m_data,
    output int                mismatches,
    output int                outstanding
);

    import sil_pkg::*;

    localparam int TABLES  = DEF_NUM_TABLES;
    localparam int ENTRIES = DEF_ENTRIES_PER_TABLE;

    logic [POS_W-1:0] iv_start   [TABLES][ENTRIES];
    logic [POS_W-1:0] iv_end     [TABLES][ENTRIES];
    int unsigned      fill_count [TABLES];
    sil_out_t         awaited_results [$];

    function automatic bit bisect_table(input int unsigned tbl, input logic [POS_W-1:0] pos,
                                        input int low, output int unsigned where);
        int lo;
        int hi;
        int mid;
        lo = low;
        hi = int'(fill_count[tbl]) - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (iv_start[tbl][mid] <= pos && pos < iv_end[tbl][mid]) begin
                where = mid;
                return 1'b1;
            end
            if (iv_start[tbl][mid] < pos)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return 1'b0;
    endfunction

    function automatic sil_out_t predict_lookup(input sil_in_t req);
        sil_out_t    res;
        int unsigned tbl;
        int unsigned cnt;
        int unsigned where;
        res   = '0;
        where = 0;
        tbl   = 32'(req.chrom);
        if (tbl < TABLES) begin
            cnt = fill_count[tbl];
            case (req.func)
                FUNC_LOAD: begin
                    if (cnt >= ENTRIES) begin
                        res.table_full = 1'b1;
                    end else begin
                        iv_start[tbl][cnt] = req.range_start;
                        iv_end[tbl][cnt]   = req.range_end;
                        fill_count[tbl]    = cnt + 1;
                    end
                end
                FUNC_SEARCH: begin
                    if (bisect_table(tbl, req.range_start, int'(req.entry_index), where))
                        res.hit = 1'b1;
                    else if (req.range_end > req.range_start &&
                             bisect_table(tbl, req.range_end, int'(req.entry_index), where))
                        res.hit = 1'b1;
                    if (res.hit)
                        res.hit_index = where[EIDX_W-1:0];
                end
                FUNC_VERIFY: begin
                    if (32'(req.entry_index) < cnt &&
                        iv_start[tbl][req.entry_index] <= req.range_start &&
                        iv_end[tbl][req.entry_index] >= req.range_end) begin
                        res.hit       = 1'b1;
                        res.hit_index = req.entry_index;
                    end
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        sil_out_t want;
        sil_out_t got;
        int       fails;
        if (!aresetn) begin
            foreach (fill_count[t])
                fill_count[t] = 0;
            awaited_results.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            fails = 0;
            if (m_valid && m_ready) begin
                got = m_data;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got hit=%0b index=%0d full=%0b",
                             $time, got.hit, got.hit_index, got.table_full);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit expected %0b, got %0b", $time, want.hit, got.hit);
                        fails++;
                    end
                    if (got.hit_index !== want.hit_index) begin
                        $display("%0t: hit_index expected %0d, got %0d",
                                 $time, want.hit_index, got.hit_index);
                        fails++;
                    end
                    if (got.table_full !== want.table_full) begin
                        $display("%0t: table_full expected %0b, got %0b",
                                 $time, want.table_full, got.table_full);
                        fails++;
                    end
                end
            end
            if (s_valid && s_ready)
                awaited_results.push_back(predict_lookup(s_data));
            mismatches  <= mismatches + fails;
            outstanding <= awaited_results.size();
        end
    end

endmodule

// File: tb/sorted_interval_lookup_core_tb.sv
`timescale 1ns / 1ps

module sorted_interval_lookup_core_tb;

    import sil_pkg::*;

    localparam int TABLES       = DEF_NUM_TABLES;
    localparam int ENTRIES      = DEF_ENTRIES_PER_TABLE;
    localparam int DEEP_TABLE   = 30;
    localparam int RANDOM_ITEMS = 320;
    localparam int IDLE_PCT     = 32;
    localparam int QUIET_FIRST  = 100;
    localparam int QUIET_LAST   = 300;
    localparam int HOLD_AT      = 620;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sil_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sil_out_t m_data;
    int       mismatches;
    int       outstanding;

    int unsigned sent_count = 0;
    bit [31:0]   plan_start  [TABLES][ENTRIES];
    bit [31:0]   plan_end    [TABLES][ENTRIES];
    int unsigned plan_count  [TABLES];
    bit [31:0]   plan_cursor [TABLES];

    sorted_interval_lookup_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    interval_lookup_checker u_lookup_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // hold off once for a long stretch so the block backs up into its input
    initial begin : result_sink
        int unsigned seen;
        int unsigned hold_left;
        bit          held;
        seen      = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                seen++;
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held && seen >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (seen >= QUIET_FIRST && seen < QUIET_LAST) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic sil_in_t pack_item(input logic [FUNC_W-1:0] f, input int unsigned tbl,
                                          input bit [31:0] rs, input bit [31:0] re,
                                          input int unsigned idx);
        sil_in_t item;
        item.func        = f;
        item.chrom       = tbl[CHROM_W-1:0];
        item.range_start = rs;
        item.range_end   = re;
        item.entry_index = idx[EIDX_W-1:0];
        return item;
    endfunction

    function automatic sil_in_t make_load(input int unsigned tbl, input int unsigned broken_pct);
        bit [31:0] rs;
        bit [31:0] re;
        if ($urandom_range(0, 99) < broken_pct) begin
            rs = $urandom;
            re = $urandom;
        end else begin
            rs = plan_cursor[tbl] + $urandom_range(0, 40);
            re = rs + $urandom_range(1, 120);
            plan_cursor[tbl] = re;
        end
        return pack_item(FUNC_LOAD, tbl, rs, re, $urandom_range(0, 511));
    endfunction

    function automatic sil_in_t make_search(input int unsigned tbl);
        int unsigned cnt;
        int unsigned k;
        int unsigned low;
        bit [31:0]   rs;
        bit [31:0]   re;
        cnt = plan_count[tbl];
        if (cnt != 0 && $urandom_range(0, 9) < 6) begin
            k  = $urandom_range(0, cnt - 1);
            rs = $urandom_range(plan_start[tbl][k], plan_end[tbl][k]);
        end else begin
            rs = $urandom_range(0, plan_cursor[tbl] + 60);
        end
        case ($urandom_range(0, 3))
            0: re = rs;
            1: re = rs + $urandom_range(1, 150);
            2: re = $urandom_range(0, rs);
            default: re = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0, 1: low = 0;
            2: low = $urandom_range(0, cnt);
            default: low = $urandom_range(0, 511);
        endcase
        return pack_item(FUNC_SEARCH, tbl, rs, re, low);
    endfunction

    function automatic sil_in_t make_verify(input int unsigned tbl);
        int unsigned cnt;
        int unsigned k;
        bit [31:0]   rs;
        bit [31:0]   re;
        cnt = plan_count[tbl];
        if (cnt != 0 && $urandom_range(0, 3) != 0) begin
            k  = $urandom_range(0, cnt - 1);
            rs = $urandom_range(plan_start[tbl][k], plan_end[tbl][k]);
            re = $urandom_range(rs, plan_end[tbl][k]);
            case ($urandom_range(0, 3))
                0: rs = plan_start[tbl][k] - 1;
                1: re = plan_end[tbl][k] + 1;
                default: ;
            endcase
        end else begin
            k  = $urandom_range(0, 511);
            rs = $urandom;
            re = $urandom;
        end
        return pack_item(FUNC_VERIFY, tbl, rs, re, k);
    endfunction

    function automatic int unsigned pick_table();
        if ($urandom_range(0, 3) == 0)
            return DEEP_TABLE;
        return $urandom_range(1, 8);
    endfunction

    task automatic offer(input sil_in_t item);
        while (!(sent_count >= QUIET_FIRST && sent_count < QUIET_LAST) &&
               $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sent_count++;
        if (item.func == FUNC_LOAD && plan_count[item.chrom] < ENTRIES) begin
            plan_start[item.chrom][plan_count[item.chrom]] = item.range_start;
            plan_end[item.chrom][plan_count[item.chrom]]   = item.range_end;
            plan_count[item.chrom]++;
        end
    endtask

    initial begin
        int unsigned sel;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        offer(pack_item(FUNC_SEARCH, 0, 15, 15, 0));
        offer(pack_item(FUNC_VERIFY, 0, 0, 0, 0));
        offer(pack_item(FUNC_LOAD, 0, 10, 20, 0));
        offer(pack_item(FUNC_LOAD, 0, 20, 40, 0));
        offer(pack_item(FUNC_LOAD, 0, 100, 200, 0));
        offer(pack_item(FUNC_LOAD, 0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 511));
        offer(pack_item(FUNC_SEARCH, 0, 15, 15, 0));
        offer(pack_item(FUNC_SEARCH, 0, 20, 20, 0));
        offer(pack_item(FUNC_SEARCH, 0, 50, 150, 0));
        offer(pack_item(FUNC_SEARCH, 0, 50, 50, 0));
        offer(pack_item(FUNC_SEARCH, 0, 150, 10, 0));
        offer(pack_item(FUNC_SEARCH, 0, 15, 300, 3));
        offer(pack_item(FUNC_SEARCH, 0, 15, 15, 511));
        offer(pack_item(FUNC_SEARCH, 0, 32'hFFFF_FFFE, 0, 0));
        offer(pack_item(FUNC_SEARCH, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        offer(pack_item(FUNC_VERIFY, 0, 20, 40, 1));
        offer(pack_item(FUNC_VERIFY, 0, 19, 40, 1));
        offer(pack_item(FUNC_VERIFY, 0, 20, 41, 1));
        offer(pack_item(FUNC_VERIFY, 0, 10, 20, 4));
        offer(pack_item(FUNC_UNUSED, 31, '1, '1, 511));
        offer(pack_item(FUNC_LOAD, 31, 0, 0, 0));
        offer(pack_item(FUNC_LOAD, 31, '1, '1, 511));
        offer(pack_item(FUNC_SEARCH, 31, 0, '1, 0));
        offer(pack_item(FUNC_VERIFY, 31, 0, 0, 0));

        // fill one table to capacity, then push past it
        for (int i = 0; i < ENTRIES + 3; i++)
            offer(make_load(DEEP_TABLE, 0));

        repeat (RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 25)
                offer(make_load(($urandom_range(0, 9) == 0) ? DEEP_TABLE : $urandom_range(1, 8),
                                10));
            else if (sel < 65)
                offer(make_search(pick_table()));
            else if (sel < 85)
                offer(make_verify(pick_table()));
            else
                offer(pack_item(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                                $urandom, $urandom, $urandom_range(0, 511)));
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
